// ===== src/ckp_pkg.sv =====
// Shared types, constants and word tables for the command line keyword parser.
// Used by ckp_match and command_line_keyword_parser_top; depends on nothing.
`timescale 1ns / 1ps

package ckp_pkg;

    localparam int NUM_CMDS   = 2;
    localparam int NUM_PARS   = 6;
    localparam int WORD_CHARS = 15;

    // Character position saturates at 31, so five bits hold it.
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam int IDX_W = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;

    // Fixed widths of the result fields.
    localparam int STATUS_W = 2;
    localparam int FORM_W   = 2;
    localparam int CMD_W    = 1;
    localparam int PAR_W    = 3;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_EQ   = 8'h3D;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

    localparam logic [FORM_W-1:0] FORM_NAME     = 2'd0;
    localparam logic [FORM_W-1:0] FORM_PAR      = 2'd1;
    localparam logic [FORM_W-1:0] FORM_VAL      = 2'd2;
    localparam logic [FORM_W-1:0] FORM_PAR_VAL  = 2'd3;

    typedef enum logic [1:0] {
        PH_NAME = 2'd0,
        PH_PAR  = 2'd1,
        PH_VAL  = 2'd2
    } t_phase;

    // Characters of a word, first character in element 0, padded with zeros.
    typedef logic [WORD_CHARS-1:0][7:0] t_chars;

    typedef struct packed {
        logic [POS_W-1:0] len;
        t_chars           chars;
    } t_word;

    typedef struct packed {
        logic [PAR_W-1:0]    par_index;
        logic [CMD_W-1:0]    cmd_index;
        logic [FORM_W-1:0]   form;
        logic [STATUS_W-1:0] status;
    } t_res;

    // String literals are written reversed so that the first character lands
    // in element 0 of the packed array.
    localparam t_word CMD_WORDS [NUM_CMDS] = '{
        '{len: 5'd5, chars: t_chars'("00dmc")},
        '{len: 5'd5, chars: t_chars'("10dmc")}
    };

    localparam t_word PAR_WORDS [NUM_CMDS][NUM_PARS] = '{
        '{
            '{len: 5'd5, chars: t_chars'("00cba")},
            '{len: 5'd5, chars: t_chars'("10fed")},
            '{len: 5'd2, chars: t_chars'("20")},
            '{len: 5'd2, chars: t_chars'("30")},
            '{len: 5'd2, chars: t_chars'("40")},
            '{len: 5'd2, chars: t_chars'("50")}
        },
        '{
            '{len: 5'd5, chars: t_chars'("01cba")},
            '{len: 5'd5, chars: t_chars'("11fed")},
            '{len: 5'd2, chars: t_chars'("21")},
            '{len: 5'd2, chars: t_chars'("31")},
            '{len: 5'd2, chars: t_chars'("41")},
            '{len: 5'd2, chars: t_chars'("51")}
        }
    };

    // A word stays alive while it has the given character at this position.
    function automatic logic keep_on_char(t_word w, logic [POS_W-1:0] pos, logic [7:0] ch);
        logic in_range;
        in_range = (pos < POS_W'(WORD_CHARS)) && (pos < w.len);
        return in_range && (w.chars[pos[IDX_W-1:0]] == ch);
    endfunction

    // At the end of a fragment a word matches only if its length is the fragment's.
    function automatic logic keep_at_end(t_word w, logic [POS_W-1:0] pos);
        return (w.len == pos) && (w.len <= POS_W'(WORD_CHARS));
    endfunction

endpackage

// ===== src/command_line_keyword_parser_top.sv =====
// Top level of the command line keyword parser: stream ports, input and result registers.
// Depends on ckp_pkg and ckp_match.
`timescale 1ns / 1ps

// The parser takes one character per beat on the slave stream and sustains one
// beat per clock cycle unless a zero byte is held back. Each character sits in
// an input register, then the match logic compares it in parallel against every
// command and parameter word and updates the match state. A zero byte ends the
// line; its result is loaded into the output register as that byte leaves the
// input register, and the match state is reset at the same time, so the next line
// may follow at once. Characters other than the zero byte never produce a result
// and are never held back by the master side; only a zero byte waits while an
// earlier result has not yet been taken. The result gives a status (recognized,
// empty line or fragment, unknown), the line's form (name, name and parameter,
// name and value, all three), and the matched command and parameter indices,
// which read zero unless the status is recognized. Value text is consumed but
// only its presence is reported. Words longer than fifteen characters never match.

module command_line_keyword_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] status, [3:2] form, [4] cmd_index,
                                       // [7:5] par_index
);

    logic          r_in_vld;
    logic [7:0]    r_in_ch;
    logic          r_out_vld;
    ckp_pkg::t_res r_out_res;

    logic          w_res_free;
    logic          w_fire;
    logic          w_line_end;
    ckp_pkg::t_res w_res;

    // The result register can take a new beat when it is empty or being drained.
    assign w_res_free    = !r_out_vld || m_axis_tready;
    assign w_line_end    = (r_in_ch == ckp_pkg::CH_NUL);
    assign w_fire        = r_in_vld && (!w_line_end || w_res_free);
    assign s_axis_tready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ch <= s_axis_tdata;
        end
    end

    ckp_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_ch    (r_in_ch),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && w_line_end) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_line_end) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_res;

endmodule

// ===== src/ckp_match.sv =====
// Match state and per-character update logic of the keyword parser.
// Depends on ckp_pkg for the word tables, phase type and result struct.
`timescale 1ns / 1ps

module ckp_match (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_ch,
    output ckp_pkg::t_res o_res
);

    ckp_pkg::t_phase                r_phase, n_phase;
    logic [ckp_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [ckp_pkg::NUM_CMDS-1:0]   r_name_alive, n_name_alive;
    logic [ckp_pkg::NUM_CMDS-1:0][ckp_pkg::NUM_PARS-1:0] r_par_alive, n_par_alive;
    logic                           r_frag, n_frag;
    logic                           r_pseen, n_pseen;

    logic [ckp_pkg::NUM_CMDS-1:0]   w_name_feed, w_name_end, w_name_fin;
    logic [ckp_pkg::NUM_CMDS-1:0][ckp_pkg::NUM_PARS-1:0] w_par_feed, w_par_end, w_par_fin;
    logic [ckp_pkg::POS_W-1:0]      w_pos_inc;

    always_comb begin
        for (int c = 0; c < ckp_pkg::NUM_CMDS; c++) begin
            w_name_feed[c] = r_name_alive[c] &
                             ckp_pkg::keep_on_char(ckp_pkg::CMD_WORDS[c], r_pos, i_ch);
            w_name_end[c]  = r_name_alive[c] &
                             ckp_pkg::keep_at_end(ckp_pkg::CMD_WORDS[c], r_pos);
            for (int p = 0; p < ckp_pkg::NUM_PARS; p++) begin
                w_par_feed[c][p] = r_par_alive[c][p] &
                    ckp_pkg::keep_on_char(ckp_pkg::PAR_WORDS[c][p], r_pos, i_ch);
                w_par_end[c][p]  = r_par_alive[c][p] &
                    ckp_pkg::keep_at_end(ckp_pkg::PAR_WORDS[c][p], r_pos);
            end
        end
        w_name_fin = (r_phase == ckp_pkg::PH_NAME) ? w_name_end : r_name_alive;
        w_par_fin  = (r_phase == ckp_pkg::PH_PAR)  ? w_par_end  : r_par_alive;
        w_pos_inc  = (r_pos == ckp_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;
    end

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_name_alive = r_name_alive;
        n_par_alive  = r_par_alive;
        n_frag       = r_frag;
        n_pseen      = r_pseen;
        if (i_fire) begin
            if (i_ch == ckp_pkg::CH_NUL) begin
                n_phase      = ckp_pkg::PH_NAME;
                n_pos        = '0;
                n_name_alive = '1;
                n_par_alive  = '1;
                n_frag       = 1'b0;
                n_pseen      = 1'b0;
            end else begin
                unique case (r_phase)
                    ckp_pkg::PH_NAME: begin
                        if (i_ch == ckp_pkg::CH_DASH || i_ch == ckp_pkg::CH_EQ) begin
                            n_name_alive = w_name_end;
                            n_phase = (i_ch == ckp_pkg::CH_DASH) ? ckp_pkg::PH_PAR
                                                                 : ckp_pkg::PH_VAL;
                            n_pseen = (i_ch == ckp_pkg::CH_DASH);
                            n_pos   = '0;
                            n_frag  = 1'b0;
                        end else begin
                            n_name_alive = w_name_feed;
                            n_pos        = w_pos_inc;
                            n_frag       = 1'b1;
                        end
                    end
                    ckp_pkg::PH_PAR: begin
                        if (i_ch == ckp_pkg::CH_EQ) begin
                            n_par_alive = w_par_end;
                            n_phase     = ckp_pkg::PH_VAL;
                            n_pos       = '0;
                            n_frag      = 1'b0;
                        end else begin
                            n_par_alive = w_par_feed;
                            n_pos       = w_pos_inc;
                            n_frag      = 1'b1;
                        end
                    end
                    ckp_pkg::PH_VAL: begin
                        n_frag = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ckp_pkg::PH_NAME;
            r_pos        <= '0;
            r_name_alive <= '1;
            r_par_alive  <= '1;
            r_frag       <= 1'b0;
            r_pseen      <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_name_alive <= n_name_alive;
            r_par_alive  <= n_par_alive;
            r_frag       <= n_frag;
            r_pseen      <= n_pseen;
        end
    end

    // Result of a line that ends with the current state; lowest index wins.
    always_comb begin
        logic                      cmd_found;
        logic [ckp_pkg::CMD_W-1:0] cmd_idx;
        logic                      par_found;
        logic [ckp_pkg::PAR_W-1:0] par_idx;
        logic [ckp_pkg::FORM_W-1:0] form;

        cmd_found = 1'b0;
        cmd_idx   = '0;
        for (int c = ckp_pkg::NUM_CMDS - 1; c >= 0; c--) begin
            if (w_name_fin[c]) begin
                cmd_found = 1'b1;
                cmd_idx   = ckp_pkg::CMD_W'(c);
            end
        end
        par_found = 1'b0;
        par_idx   = '0;
        for (int p = ckp_pkg::NUM_PARS - 1; p >= 0; p--) begin
            if (w_par_fin[cmd_idx][p]) begin
                par_found = 1'b1;
                par_idx   = ckp_pkg::PAR_W'(p);
            end
        end

        unique case (r_phase)
            ckp_pkg::PH_NAME: form = ckp_pkg::FORM_NAME;
            ckp_pkg::PH_PAR:  form = ckp_pkg::FORM_PAR;
            ckp_pkg::PH_VAL:  form = r_pseen ? ckp_pkg::FORM_PAR_VAL : ckp_pkg::FORM_VAL;
            default:          form = ckp_pkg::FORM_NAME;
        endcase

        o_res = '0;
        if (!r_frag) begin
            o_res.status = ckp_pkg::ST_EMPTY;
        end else if (!cmd_found || (r_pseen && !par_found)) begin
            o_res.status = ckp_pkg::ST_UNKNOWN;
            o_res.form   = form;
        end else begin
            o_res.status    = ckp_pkg::ST_OK;
            o_res.form      = form;
            o_res.cmd_index = cmd_idx;
            o_res.par_index = r_pseen ? par_idx : '0;
        end
    end

endmodule

// ===== src/ckp_checker.sv =====
// Port-level checks for the command line keyword parser, bound to its top level.
// Depends on command_line_keyword_parser_top's ports only.
`timescale 1ns / 1ps

module ckp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled result beat holds its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Status is never the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("unused status code");

    // An empty line reports name-only form and zero indices.
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd1 |-> m_axis_tdata[7:2] == 6'd0)
        else $error("empty status with nonzero fields");

    // An unknown line reports zero indices.
    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd2 |-> m_axis_tdata[7:4] == 4'd0)
        else $error("unknown status with nonzero indices");

    // A parameter index appears only when the form includes a parameter.
    a_par_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7:5] != 3'd0 |-> m_axis_tdata[2])
        else $error("parameter index without parameter form");

endmodule

bind command_line_keyword_parser_top ckp_checker u_ckp_checker (.*);

// ===== verif/command_line_keyword_parser_checker.sv =====
// Checker for the command line keyword parser: watches both stream channels,
// predicts each line's result and compares it field by field. Depends on ckp_pkg.
`timescale 1ns / 1ps

module command_line_keyword_parser_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,     // [7:0] ch
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,    // [1:0] status, [3:2] form, [4] cmd_index,
                                      // [7:5] par_index
    input  logic       i_end_check,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int POS_TOP = 31;

    string cmd_names [ckp_pkg::NUM_CMDS] = '{"cmd00", "cmd01"};
    string par_names [ckp_pkg::NUM_CMDS][ckp_pkg::NUM_PARS] = '{
        '{"abc00", "def01", "02", "03", "04", "05"},
        '{"abc10", "def11", "12", "13", "14", "15"}
    };

    ckp_pkg::t_phase              line_phase;
    int                           word_pos;
    logic [ckp_pkg::NUM_CMDS-1:0] cmd_live;
    logic [ckp_pkg::NUM_PARS-1:0] par_live [ckp_pkg::NUM_CMDS];
    logic                         frag_filled;
    logic                         par_opened;
    ckp_pkg::t_res                line_results [$];
    bit                           leftover_checked = 1'b0;

    // A word survives a character only inside its length and the word limit.
    function automatic logic still_matches(string w, int pos, logic [7:0] ch);
        if (pos >= ckp_pkg::WORD_CHARS || pos >= w.len())
            return 1'b0;
        return 8'(w.getc(pos)) == ch;
    endfunction

    function automatic logic ends_here(string w, int pos);
        return (w.len() == pos) && (w.len() <= ckp_pkg::WORD_CHARS);
    endfunction

    task automatic clear_line();
        line_phase  = ckp_pkg::PH_NAME;
        word_pos    = 0;
        cmd_live    = '1;
        for (int c = 0; c < ckp_pkg::NUM_CMDS; c++)
            par_live[c] = '1;
        frag_filled = 1'b0;
        par_opened  = 1'b0;
    endtask

    task automatic close_name();
        for (int c = 0; c < ckp_pkg::NUM_CMDS; c++)
            if (!ends_here(cmd_names[c], word_pos))
                cmd_live[c] = 1'b0;
    endtask

    task automatic close_par();
        for (int c = 0; c < ckp_pkg::NUM_CMDS; c++)
            for (int p = 0; p < ckp_pkg::NUM_PARS; p++)
                if (!ends_here(par_names[c][p], word_pos))
                    par_live[c][p] = 1'b0;
    endtask

    task automatic advance_pos();
        if (word_pos < POS_TOP)
            word_pos++;
        frag_filled = 1'b1;
    endtask

    // Updates the match state for one character; a zero byte yields the line result.
    task automatic take_char(logic [7:0] ch);
        ckp_pkg::t_res r;
        int            hit_cmd;
        int            hit_par;
        r       = '0;
        hit_cmd = -1;
        hit_par = -1;
        if (ch != ckp_pkg::CH_NUL) begin
            case (line_phase)
                ckp_pkg::PH_NAME: begin
                    if (ch == ckp_pkg::CH_DASH || ch == ckp_pkg::CH_EQ) begin
                        close_name();
                        line_phase  = (ch == ckp_pkg::CH_DASH) ? ckp_pkg::PH_PAR
                                                               : ckp_pkg::PH_VAL;
                        par_opened  = (ch == ckp_pkg::CH_DASH);
                        word_pos    = 0;
                        frag_filled = 1'b0;
                    end else begin
                        for (int c = 0; c < ckp_pkg::NUM_CMDS; c++)
                            if (!still_matches(cmd_names[c], word_pos, ch))
                                cmd_live[c] = 1'b0;
                        advance_pos();
                    end
                end
                ckp_pkg::PH_PAR: begin
                    if (ch == ckp_pkg::CH_EQ) begin
                        close_par();
                        line_phase  = ckp_pkg::PH_VAL;
                        word_pos    = 0;
                        frag_filled = 1'b0;
                    end else begin
                        for (int c = 0; c < ckp_pkg::NUM_CMDS; c++)
                            for (int p = 0; p < ckp_pkg::NUM_PARS; p++)
                                if (!still_matches(par_names[c][p], word_pos, ch))
                                    par_live[c][p] = 1'b0;
                        advance_pos();
                    end
                end
                default: frag_filled = 1'b1;
            endcase
            return;
        end

        if (!frag_filled) begin
            r.status = ckp_pkg::ST_EMPTY;
        end else begin
            case (line_phase)
                ckp_pkg::PH_NAME: begin
                    close_name();
                    r.form = ckp_pkg::FORM_NAME;
                end
                ckp_pkg::PH_PAR: begin
                    close_par();
                    r.form = ckp_pkg::FORM_PAR;
                end
                default: r.form = par_opened ? ckp_pkg::FORM_PAR_VAL : ckp_pkg::FORM_VAL;
            endcase
            for (int c = 0; c < ckp_pkg::NUM_CMDS; c++)
                if (cmd_live[c] && hit_cmd < 0)
                    hit_cmd = c;
            if (hit_cmd < 0) begin
                r.status = ckp_pkg::ST_UNKNOWN;
            end else begin
                r.status    = ckp_pkg::ST_OK;
                r.cmd_index = ckp_pkg::CMD_W'(hit_cmd);
                if (par_opened) begin
                    for (int p = 0; p < ckp_pkg::NUM_PARS; p++)
                        if (par_live[hit_cmd][p] && hit_par < 0)
                            hit_par = p;
                    if (hit_par < 0) begin
                        r.status    = ckp_pkg::ST_UNKNOWN;
                        r.cmd_index = '0;
                    end else begin
                        r.par_index = ckp_pkg::PAR_W'(hit_par);
                    end
                end
            end
        end
        line_results.push_back(r);
        clear_line();
    endtask

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        ckp_pkg::t_res got;
        ckp_pkg::t_res want;
        if (!i_rst_n) begin
            clear_line();
            line_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                take_char(i_in_data);
            if (i_out_valid && i_out_ready) begin
                got = ckp_pkg::t_res'(i_out_data);
                if (line_results.size() == 0) begin
                    $error("result beat with no line pending: tdata %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = line_results.pop_front();
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("form", 8'(want.form), 8'(got.form));
                    check_field("cmd_index", 8'(want.cmd_index), 8'(got.cmd_index));
                    check_field("par_index", 8'(want.par_index), 8'(got.par_index));
                end
            end
            if (i_end_check && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (line_results.size() != 0) begin
                    $error("%0d line results never arrived", line_results.size());
                    o_fail_count++;
                end
            end
        end
        o_pending = line_results.size();
    end

endmodule

// ===== verif/command_line_keyword_parser_top_test.sv =====
// Testbench top for the command line keyword parser: clock, reset, character
// stimulus and result-side stalls. Depends on ckp_pkg, the parser and its checker.
`timescale 1ns / 1ps

module command_line_keyword_parser_top_test;

    // Roughly how many characters to send before the run winds down.
    localparam int ITEM_TARGET = 1750;
    // Cycles to wait for outstanding results once stimulus is over.
    localparam int DRAIN_LIMIT = 4000;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;     // [7:0] ch
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [1:0] status, [3:2] form, [4] cmd_index,
                                        // [7:5] par_index
    logic       end_check     = 1'b0;
    int         fail_count;
    int         pending;

    // Characters of the line under construction, without its closing zero byte.
    logic [7:0] line_buf [$];
    int         sent_chars   = 0;
    bit         tx_calm      = 1'b0;
    bit         rx_calm      = 1'b0;
    int         rx_hold      = 0;
    bit         drained_once = 1'b0;

    // The same words the block is built with; most random lines are made from
    // them so that the match logic gets past its first character.
    string cmd_names [ckp_pkg::NUM_CMDS] = '{"cmd00", "cmd01"};
    string par_names [ckp_pkg::NUM_CMDS][ckp_pkg::NUM_PARS] = '{
        '{"abc00", "def01", "02", "03", "04", "05"},
        '{"abc10", "def11", "12", "13", "14", "15"}
    };
    // Characters that occur in table words, used to build near misses.
    string alphabet = "cmdabef012345";

    always #10 i_clk = ~i_clk;

    command_line_keyword_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    command_line_keyword_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_end_check  (end_check),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Idle stretches are mostly short, sometimes of middle length, and now and
    // then long enough to let the other side run dry or fill up.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A word character: never '=', and '-' only where the phase treats it as text.
    // A third of the picks come from the table alphabet to make near matches.
    function automatic logic [7:0] pick_char(bit allow_dash);
        logic [7:0] c;
        c = ckp_pkg::CH_EQ;
        while (c == ckp_pkg::CH_EQ || (!allow_dash && c == ckp_pkg::CH_DASH)) begin
            if ($urandom_range(0, 2) == 0)
                c = 8'(alphabet.getc($urandom_range(0, alphabet.len() - 1)));
            else
                c = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    // Sends one character beat. Called and returning just after a falling edge,
    // so valid is only ever written once per time step: either lowered for a
    // gap, or left high and given the next character.
    task automatic send_char(logic [7:0] ch);
        int gap;
        gap = (!tx_calm && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge i_clk);
        sent_chars++;
        @(negedge i_clk);
    endtask

    task automatic push_text(string text);
        for (int i = 0; i < text.len(); i++)
            line_buf.push_back(8'(text.getc(i)));
    endtask

    task automatic push_random(int count, bit allow_dash);
        repeat (count)
            line_buf.push_back(pick_char(allow_dash));
    endtask

    // Any nonzero byte, '-' and '=' included, as value text or line noise.
    task automatic push_bytes(int count);
        repeat (count)
            line_buf.push_back(8'($urandom_range(1, 255)));
    endtask

    // A table word with its last character dropped or one extra appended, the near
    // misses that must not match, or left whole.
    task automatic push_variant(string w, bit allow_dash);
        push_text(w);
        case ($urandom_range(0, 2))
            0: void'(line_buf.pop_back());
            1: line_buf.push_back(pick_char(allow_dash));
            default: ;
        endcase
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        send_char(ckp_pkg::CH_NUL);
        line_buf.delete();
    endtask

    task automatic push_name(output int which);
        int r;
        which = $urandom_range(0, ckp_pkg::NUM_CMDS - 1);
        r     = $urandom_range(0, 99);
        if (r < 60)
            push_text(cmd_names[which]);
        else if (r < 78)
            push_variant(cmd_names[which], 1'b0);
        else if (r < 93)
            push_random($urandom_range(0, 6), 1'b0);
        else
            push_random($urandom_range(14, 40), 1'b0);
    endtask

    // Mostly a parameter word of the chosen command; sometimes one from a random
    // command's row, which must be rejected when that is the other command.
    task automatic push_param(int which);
        int r;
        int row;
        row = ($urandom_range(0, 99) < 30) ? $urandom_range(0, ckp_pkg::NUM_CMDS - 1)
                                           : which;
        r   = $urandom_range(0, 99);
        if (r < 60)
            push_text(par_names[row][$urandom_range(0, ckp_pkg::NUM_PARS - 1)]);
        else if (r < 75)
            push_variant(par_names[row][$urandom_range(0, ckp_pkg::NUM_PARS - 1)], 1'b1);
        else if (r < 92)
            push_random($urandom_range(0, 5), 1'b1);
        else
            push_random($urandom_range(14, 40), 1'b1);
    endtask

    // Stops the character stream until every line sent so far has its result.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // The result side stalls in bursts; at random moments it switches between a
    // stalling mood and a stretch where it always takes the beat.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            rx_calm = !rx_calm;
        if (rx_hold == 0 && !rx_calm && $urandom_range(0, 99) < 25)
            rx_hold = gap_len();
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("command_line_keyword_parser_top test failed");
        $finish;
    end

    initial begin : stimulus
        int        which;
        int        waited;
        logic [1:0] shape;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: an empty line, an empty value after an empty name, an
        // empty name and parameter ahead of a value (unknown, with the top byte
        // value), an empty parameter at the end, and a full recognized line
        // with the lowest nonzero byte as its value.
        send_line();
        line_buf.push_back(ckp_pkg::CH_EQ);
        send_line();
        line_buf.push_back(ckp_pkg::CH_DASH);
        line_buf.push_back(ckp_pkg::CH_EQ);
        line_buf.push_back(8'hFF);
        send_line();
        push_text("cmd01-");
        send_line();
        push_text("cmd01-15=");
        line_buf.push_back(8'h01);
        send_line();

        // Random lines: most are well-formed name, parameter and value
        // sequences with random content; about one in ten is plain noise.
        while (sent_chars < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 8)
                tx_calm = !tx_calm;
            if ($urandom_range(0, 99) < 10) begin
                push_bytes($urandom_range(0, 12));
            end else begin
                push_name(which);
                shape = 2'($urandom_range(0, 3));
                if (shape == ckp_pkg::FORM_PAR || shape == ckp_pkg::FORM_PAR_VAL) begin
                    line_buf.push_back(ckp_pkg::CH_DASH);
                    push_param(which);
                end
                if (shape == ckp_pkg::FORM_VAL || shape == ckp_pkg::FORM_PAR_VAL) begin
                    line_buf.push_back(ckp_pkg::CH_EQ);
                    push_bytes($urandom_range(0, 6));
                end
            end
            send_line();
            if (!drained_once && sent_chars >= ITEM_TARGET / 2) begin
                drained_once = 1'b1;
                wait_drained();
            end
        end

        // Let the last results come out or the drain limit run out, then have the
        // checker flag anything still outstanding.
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(negedge i_clk);

        if (fail_count == 0)
            $display("command_line_keyword_parser_top test passed");
        else
            $display("command_line_keyword_parser_top test failed");
        $finish;
    end

endmodule
